// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ARTB_ASSERT(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Checks that a trigger is followed by the condition holding in the next cycle.
`define ARTB_ASSERT_NEXT(name, clk, rst_n, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("assertion failed");

`endif

// ===== src/artb_pkg.sv =====
package artb_pkg;

	// Operation codes carried in the func field.
	localparam logic [3:0] FUNC_TICK   = 4'd0;
	localparam logic [3:0] FUNC_CHECK  = 4'd1;
	localparam logic [3:0] FUNC_CREATE = 4'd2;
	localparam logic [3:0] FUNC_REMOVE = 4'd3;
	localparam logic [3:0] FUNC_READY  = 4'd4;
	localparam logic [3:0] FUNC_RESET  = 4'd5;
	localparam logic [3:0] FUNC_PAUSE  = 4'd6;
	localparam logic [3:0] FUNC_RESUME = 4'd7;
	localparam logic [3:0] FUNC_QUERY  = 4'd8;

	// Status codes.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_INDEX = 1'b1;

	// A check reports at most this many expired timers.
	localparam int MAX_FIRES = 16;
	localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

	// Request word.
	typedef struct packed {
		logic [3:0]  func;
		logic [7:0]  timer_index;
		logic [31:0] reload_value;
		logic        reload_enable;
		logic        run_enable;
	} req_t;

	// Response word.
	typedef struct packed {
		logic        status;
		logic        fired;
		logic [3:0]  fired_index;
		logic        running;
		logic [31:0] tick_total;
		logic        last;
	} rsp_t;

	// One timer as held in the timer memory.
	typedef struct packed {
		logic [31:0] count;
		logic [31:0] reload;
		logic        run;
		logic        auto_reload;
	} entry_t;

	// A response word handed from the sequencer to the output register.
	typedef struct packed {
		logic vld;
		rsp_t word;
	} push_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} seq_state_t;

endpackage

// ===== src/artb_ram.sv =====
module artb_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/artb_seq.sv =====
module artb_seq import artb_pkg::*; #(
	parameter int TIMER_COUNT = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	input  entry_t           rd_data,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output entry_t           wr_data,
	output push_t            push,
	input  logic             out_free
);

	seq_state_t             state_q, state_d;
	logic [3:0]             func_q;
	logic [IDX_W-1:0]       cur_q;
	logic [31:0]            rv_q;
	logic                   ren_q;
	logic                   run_q;
	logic [31:0]            tick_q;
	logic [TIMER_COUNT-1:0] valid_q;
	logic                   pend_vld_q;
	logic [3:0]             pend_idx_q;
	logic [FIRE_W-1:0]      nfire_q;
	logic                   fin_status_q;
	logic                   fin_running_q;

	logic   acc;
	logic   in_range;
	logic   req_sweep;
	logic   req_single;
	logic   op_sweep;
	entry_t ent;
	logic   last_ent;
	logic   hit;
	logic   blocked;
	logic   sweep_end;

	// Decode of the incoming word.
	assign acc        = req_valid && (state_q == ST_IDLE);
	assign req_stall  = (state_q != ST_IDLE);
	assign in_range   = req.timer_index < 8'(TIMER_COUNT);
	assign req_sweep  = (req.func == FUNC_TICK) || (req.func == FUNC_CHECK);
	assign req_single = (req.func >= FUNC_CREATE) && (req.func <= FUNC_QUERY) && in_range;

	// Evaluation of the entry last read from the timer memory. An entry never
	// written reads as zero through its valid bit.
	assign op_sweep  = (func_q == FUNC_TICK) || (func_q == FUNC_CHECK);
	assign ent       = valid_q[cur_q] ? rd_data : '0;
	assign last_ent  = (cur_q == IDX_W'(TIMER_COUNT - 1));
	assign hit       = (func_q == FUNC_CHECK) && ent.run && (ent.count == 32'd0);
	assign blocked   = hit && pend_vld_q && !out_free;
	assign sweep_end = last_ent || (hit && (nfire_q == FIRE_W'(MAX_FIRES - 1)));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = (req_sweep || req_single) ? ST_SWEEP : ST_FINISH;
				end
			end
			ST_SWEEP: begin
				if (!op_sweep) begin
					state_d = ST_FINISH;
				end else if (!blocked && sweep_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory accesses and response words.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q + IDX_W'(1);
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = ent;
		push    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (req_sweep || req_single)) begin
					rd_en   = 1'b1;
					rd_addr = req_sweep ? '0 : req.timer_index[IDX_W-1:0];
				end
			end
			ST_SWEEP: begin
				if (op_sweep && !blocked && !sweep_end) begin
					rd_en = 1'b1;
				end
				case (func_q)
					FUNC_TICK: begin
						wr_en = 1'b1;
						if (ent.run && (ent.count != 32'd0)) begin
							wr_data.count = ent.count - 32'd1;
						end
					end
					FUNC_CHECK: begin
						wr_en = hit && !blocked;
						if (ent.auto_reload) begin
							wr_data.count = ent.reload;
						end else begin
							wr_data = '0;
						end
					end
					FUNC_CREATE: begin
						wr_en   = 1'b1;
						wr_data = '{count: rv_q, reload: rv_q, run: run_q, auto_reload: ren_q};
					end
					FUNC_REMOVE: begin
						wr_en   = 1'b1;
						wr_data = '0;
					end
					FUNC_READY: begin
						wr_en         = 1'b1;
						wr_data.count = 32'd0;
					end
					FUNC_RESET: begin
						wr_en         = 1'b1;
						wr_data.count = ent.reload;
					end
					FUNC_PAUSE: begin
						wr_en       = 1'b1;
						wr_data.run = 1'b0;
					end
					FUNC_RESUME: begin
						wr_en       = 1'b1;
						wr_data.run = 1'b1;
					end
					default: wr_en = 1'b0;
				endcase
				// A new expiry pushes out the one held back before it.
				if (hit && !blocked && pend_vld_q) begin
					push.vld              = 1'b1;
					push.word.status      = STATUS_OK;
					push.word.fired       = 1'b1;
					push.word.fired_index = pend_idx_q;
					push.word.tick_total  = tick_q;
					push.word.last        = 1'b0;
				end
			end
			ST_FINISH: begin
				push.vld             = out_free;
				push.word.tick_total = tick_q;
				push.word.last       = 1'b1;
				if (pend_vld_q) begin
					push.word.fired       = 1'b1;
					push.word.fired_index = pend_idx_q;
				end else begin
					push.word.status  = fin_status_q;
					push.word.running = fin_running_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control state and operation registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tick_q        <= '0;
			valid_q       <= '0;
			pend_vld_q    <= 1'b0;
			nfire_q       <= '0;
			func_q        <= FUNC_TICK;
			cur_q         <= '0;
			fin_status_q  <= STATUS_OK;
			fin_running_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				func_q        <= req.func;
				cur_q         <= req_sweep ? '0 : req.timer_index[IDX_W-1:0];
				pend_vld_q    <= 1'b0;
				nfire_q       <= '0;
				fin_running_q <= 1'b0;
				fin_status_q  <= (req.func >= FUNC_CREATE && req.func <= FUNC_QUERY && !in_range)
					? STATUS_BAD_INDEX : STATUS_OK;
				if (req.func == FUNC_TICK) begin
					tick_q <= tick_q + 32'd1;
				end
			end
			if (wr_en) begin
				valid_q[cur_q] <= 1'b1;
			end
			if (state_q == ST_SWEEP && rd_en) begin
				cur_q <= cur_q + IDX_W'(1);
			end
			if (state_q == ST_SWEEP && hit && !blocked) begin
				pend_vld_q <= 1'b1;
				nfire_q    <= nfire_q + FIRE_W'(1);
			end
			if (state_q == ST_SWEEP && func_q == FUNC_QUERY) begin
				fin_running_q <= ent.run;
			end
		end
	end

	// Operand and report registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			rv_q  <= req.reload_value;
			ren_q <= req.reload_enable;
			run_q <= req.run_enable;
		end
		if (state_q == ST_SWEEP && hit && !blocked) begin
			pend_idx_q <= 4'(cur_q);
		end
	end

endmodule

// ===== src/auto_reload_timer_bank_unit.sv =====
// Channel  Direction  Word    Accepted when
// req      in         req_t   req_valid && !req_stall
// rsp      out        rsp_t   rsp_valid && !rsp_stall
//
// Tick and check sweep the bank after accept with one timer memory read and
// write-back per cycle, unless a check pauses or ends at MAX_FIRES expiries,
// then report; a valid single-timer op handles one entry, others only report.
// No clearing pass follows reset: per-timer valid bits make unwritten entries
// read as zero. A stalled response holds every final word, and pauses a check
// sweep when a second expired timer is found while the first still waits.
`include "assert_macros.svh"

module auto_reload_timer_bank_unit import artb_pkg::*; #(
	parameter int TIMER_COUNT = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	push_t            push;
	logic             out_free;
	logic             out_vld_q;
	rsp_t             out_q;

	// Timer memory, one entry per timer.
	artb_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TIMER_COUNT)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Operation sequencer.
	artb_seq #(
		.TIMER_COUNT(TIMER_COUNT),
		.IDX_W      (IDX_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.push     (push),
		.out_free (out_free)
	);

	// Output register; it can take a new word in the cycle the old one leaves.
	assign out_free = !out_vld_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.vld) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			out_q <= push.word;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	// A word is only handed over when the output register has room.
	`ARTB_ASSERT(a_push_room, clk, arst_n, !push.vld || out_free)
	// No response is produced while the sequencer is waiting for a request.
	`ARTB_ASSERT(a_idle_quiet, clk, arst_n, req_stall || !push.vld)
	// The final word of an operation frees the request side next cycle.
	`ARTB_ASSERT_NEXT(a_last_frees, clk, arst_n, push.vld && push.word.last, !req_stall)

endmodule
